// File: rtl/mbd_pkg.sv
// mbd_pkg: constants and elaboration-time table builders for the mip box downsampler
// the srgb decode and encode threshold tables are computed exactly with wide integers
// no dependencies
package mbd_pkg;

    localparam int TEXEL_BYTES  = 4;
    localparam int BYTE_W       = 8;
    localparam int NUM_CODES    = 256;
    localparam int NUM_THRESH   = 255;
    localparam int CODE_W       = 8;
    localparam int LIN_SUM_W    = 10;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int PIPE_DEPTH   = 4;
    localparam int ALPHA_LANE   = 3;
    localparam int BIG_W        = 512;

    // register index of srgb_mode, taken from paddr[2]
    localparam logic REG_SRGB_MODE = 1'b0;

    function automatic logic [BIG_W-1:0] mbd_pow12(input logic [31:0] v);
        logic [BIG_W-1:0] r;
        r = BIG_W'(1);
        for (int i = 0; i < 12; i++) begin
            r = r * BIG_W'(v);
        end
        return r;
    endfunction

    function automatic logic [BIG_W-1:0] mbd_pow5(input logic [31:0] v);
        logic [BIG_W-1:0] r;
        r = BIG_W'(1);
        for (int i = 0; i < 5; i++) begin
            r = r * BIG_W'(v);
        end
        return r;
    endfunction

    // decode entry: round(lin * 2^f), limited to 2^f - 1
    function automatic logic [31:0] mbd_decode_entry(input int f, input int c);
        logic [63:0]      n;
        logic [31:0]      v;
        logic [31:0]      lo;
        logic [31:0]      hi;
        logic [31:0]      mid;
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] den12;
        logic [BIG_W-1:0] lhs;
        if (c <= 10) begin
            n = 64'(c) * 64'd100 * (64'd1 << (f + 1));
            v = 32'((n + 64'd329460) / 64'd658920);
        end else begin
            lo    = 32'd0;
            hi    = (32'd1 << f) + 32'd1;
            rhs   = mbd_pow12(32'(1000 * c + 14025)) << (5 * (f + 1));
            den12 = mbd_pow12(32'd269025);
            while (hi - lo > 32'd1) begin
                mid = lo + ((hi - lo) >> 1);
                lhs = den12 * mbd_pow5(2 * mid - 32'd1);
                if (lhs <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
            v = lo;
        end
        if (v > (32'd1 << f) - 32'd1) begin
            v = (32'd1 << f) - 32'd1;
        end
        return v;
    endfunction

    // encode threshold k: ceil(lin((k + 1/2) / 255) * 2^(f+2))
    function automatic logic [31:0] mbd_thresh_entry(input int f, input int k);
        logic [63:0]      n;
        logic [31:0]      a;
        logic [31:0]      lo;
        logic [31:0]      hi;
        logic [31:0]      mid;
        logic [31:0]      t;
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] den12;
        logic [BIG_W-1:0] lhs;
        a = 32'(2 * k + 1);
        if (k <= 9) begin
            n = 64'(a) * 64'd100 * (64'd1 << (f + 2));
            t = 32'((n + 64'd658919) / 64'd658920);
        end else begin
            lo    = 32'd0;
            hi    = 32'd1 << (f + 2);
            rhs   = mbd_pow12(32'd1000 * a + 32'd28050) << (5 * (f + 2));
            den12 = mbd_pow12(32'd538050);
            while (hi - lo > 32'd1) begin
                mid = lo + ((hi - lo) >> 1);
                lhs = den12 * mbd_pow5(mid);
                if (lhs >= rhs) begin
                    hi = mid;
                end else begin
                    lo = mid;
                end
            end
            t = hi;
        end
        return t;
    endfunction

endpackage

// File: rtl/mbd_lane.sv
// mbd_lane: one channel of the quad, four texel bytes in, one averaged byte out
// srgb path: decode table, sum, threshold compare, thermometer to binary
// depends on mbd_pkg
module mbd_lane #(
    parameter int LINEAR_FRACTION_BITS = 20
) (
    input  logic       i_clk,
    input  logic       i_mode,
    input  logic [3:0][7:0] i_texel_byte,
    output logic [7:0] o_q
);
    import mbd_pkg::*;

    localparam int F     = LINEAR_FRACTION_BITS;
    localparam int SUM_W = F + 2;

    logic [F-1:0]        w_dec_tab [NUM_CODES];
    logic [SUM_W-1:0]    w_thr_tab [NUM_THRESH];

    for (genvar c = 0; c < NUM_CODES; c++) begin : g_dec
        localparam logic [31:0] DEC_VAL = mbd_decode_entry(F, c);
        assign w_dec_tab[c] = DEC_VAL[F-1:0];
    end

    for (genvar k = 0; k < NUM_THRESH; k++) begin : g_thr
        localparam logic [31:0] THR_VAL = mbd_thresh_entry(F, k);
        assign w_thr_tab[k] = THR_VAL[SUM_W-1:0];
    end

    // stage 1: table lookups and plain byte sum
    logic [F-1:0]          r_dec [TEXEL_BYTES];
    logic [LIN_SUM_W-1:0]  r_lin_sum1;
    logic                  r_mode1;
    logic [LIN_SUM_W-1:0]  n_lin_sum1;

    always_comb begin
        n_lin_sum1 = '0;
        for (int i = 0; i < TEXEL_BYTES; i++) begin
            n_lin_sum1 = n_lin_sum1 + LIN_SUM_W'(i_texel_byte[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TEXEL_BYTES; i++) begin
            r_dec[i] <= w_dec_tab[i_texel_byte[i]];
        end
        r_lin_sum1 <= n_lin_sum1;
        r_mode1    <= i_mode;
    end

    // stage 2: linear sum of decoded values, rounded plain mean
    logic [SUM_W-1:0]     r_dec_sum;
    logic [CODE_W-1:0]    r_lin_avg2;
    logic                 r_mode2;
    logic [SUM_W-1:0]     n_dec_sum;
    logic [LIN_SUM_W-1:0] n_lin_round;

    always_comb begin
        n_dec_sum = '0;
        for (int i = 0; i < TEXEL_BYTES; i++) begin
            n_dec_sum = n_dec_sum + SUM_W'(r_dec[i]);
        end
        n_lin_round = r_lin_sum1 + LIN_SUM_W'(2);
    end

    always_ff @(posedge i_clk) begin
        r_dec_sum  <= n_dec_sum;
        r_lin_avg2 <= n_lin_round[LIN_SUM_W-1:2];
        r_mode2    <= r_mode1;
    end

    // stage 3: compare against every decision point, thermometer code
    logic [NUM_THRESH-1:0] r_therm;
    logic [CODE_W-1:0]     r_lin_avg3;
    logic                  r_mode3;
    logic [NUM_THRESH-1:0] n_therm;

    always_comb begin
        for (int k = 0; k < NUM_THRESH; k++) begin
            n_therm[k] = (r_dec_sum >= w_thr_tab[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_therm    <= n_therm;
        r_lin_avg3 <= r_lin_avg2;
        r_mode3    <= r_mode2;
    end

    // thermometer to binary: bit b is the parity of taps at multiples of 2^b
    logic [CODE_W-1:0] w_enc;

    always_comb begin
        w_enc = '0;
        for (int b = 0; b < CODE_W; b++) begin
            for (int m = 1; m <= NUM_THRESH; m++) begin
                if (m <= (NUM_THRESH >> b)) begin
                    w_enc[b] = w_enc[b] ^ r_therm[CODE_W'((m << b) - 1)];
                end
            end
        end
    end

    assign o_q = r_mode3 ? w_enc : r_lin_avg3;

endmodule

// File: rtl/mbd_cfg.sv
// mbd_cfg: apb register file holding srgb_mode
// one 32-bit register at byte address 0, pready tied high
// depends on mbd_pkg
module mbd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mbd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mbd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    output logic                          o_srgb_mode
);
    import mbd_pkg::*;

    logic r_srgb_mode;
    logic w_sel_mode;

    assign w_sel_mode = (paddr[CFG_ADDR_W-1] == REG_SRGB_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srgb_mode <= 1'b0;
        end else if (psel && penable && pwrite && w_sel_mode) begin
            r_srgb_mode <= pwdata[0];
        end
    end

    assign prdata      = w_sel_mode ? {{(CFG_DATA_W-1){1'b0}}, r_srgb_mode} : '0;
    assign pready      = 1'b1;
    assign o_srgb_mode = r_srgb_mode;

endmodule

// File: rtl/mip_box_downsample_rgba8_top.sv
// mip_box_downsample_rgba8_top: 2x2 box filter for one rgba8 quad per clock
// throughput: one quad per clock, busy stays low, three lane stages plus the merge register
// reset: synchronous active-low, clears the pipeline valid bits and srgb_mode
// the receiver cannot stall, each result beat shows for one cycle on o_valid
// depends on mbd_pkg, mbd_lane, mbd_cfg
module mip_box_downsample_rgba8_top #(
    parameter int LINEAR_FRACTION_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [31:0]                   i_top_left,
    input  logic [31:0]                   i_top_right,
    input  logic [31:0]                   i_bottom_left,
    input  logic [31:0]                   i_bottom_right,
    output logic                          o_valid,
    output logic [31:0]                   o_averaged_texel,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mbd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mbd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready
);
    import mbd_pkg::*;

    logic                   w_srgb_mode;
    logic                   w_accept;
    logic [PIPE_DEPTH-1:0]  r_vld;
    logic [TEXEL_BYTES-1:0][BYTE_W-1:0] w_q;
    logic [31:0]            r_texel;
    logic [31:0]            w_texel [TEXEL_BYTES];

    mbd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_srgb_mode (w_srgb_mode)
    );

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_texel[0] = i_top_left;
    assign w_texel[1] = i_top_right;
    assign w_texel[2] = i_bottom_left;
    assign w_texel[3] = i_bottom_right;

    for (genvar ch = 0; ch < TEXEL_BYTES; ch++) begin : g_lane
        logic [TEXEL_BYTES-1:0][BYTE_W-1:0] w_bytes;
        logic                               w_mode;

        for (genvar t = 0; t < TEXEL_BYTES; t++) begin : g_byte
            assign w_bytes[t] = w_texel[t][ch*BYTE_W +: BYTE_W];
        end

        // alpha always takes the plain mean
        assign w_mode = (ch == ALPHA_LANE) ? 1'b0 : w_srgb_mode;

        mbd_lane #(
            .LINEAR_FRACTION_BITS (LINEAR_FRACTION_BITS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_mode       (w_mode),
            .i_texel_byte (w_bytes),
            .o_q          (w_q[ch])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], w_accept};
        end
    end

    // merge stage: pack the four lane bytes into the output texel
    always_ff @(posedge i_clk) begin
        r_texel <= w_q;
    end

    assign o_valid          = r_vld[PIPE_DEPTH-1];
    assign o_averaged_texel = r_texel;

endmodule
